// File: rtl/depi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depi_pkg
// Shared types and constants of the depth pixel to point pipeline.
// ----------------------------------------------------------------------------
package depi_pkg;

	localparam int DIV_STAGES = 32;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 64;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_PRINCIPAL_POINT  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_INVERSE_FOCAL    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISPARITY_OFFSET = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_DEPTH_SCALE      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_X            = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_Y            = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_Z            = 3'd6;

	localparam logic [31:0] RST_PRINCIPAL_POINT  = 32'd1423195311;
	localparam logic [63:0] RST_INVERSE_FOCAL    = 64'd31043920543539688;
	localparam logic [10:0] RST_DISPARITY_OFFSET = 11'd1084;
	localparam logic [31:0] RST_DEPTH_SCALE      = 32'd23365459;
	localparam logic [63:0] RST_ROW_X            = 64'd4611686018427387904;
	localparam logic [63:0] RST_ROW_Y            = 64'd70368744177664;
	localparam logic [63:0] RST_ROW_Z            = 64'd1073741824;

	typedef struct packed {
		logic [15:0] raw_depth;
		logic [9:0]  column;
		logic [9:0]  line;
	} pixel_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               point_valid;
	} point_t;

	// per-item data that rides alongside the divider
	typedef struct packed {
		logic               miss;
		logic signed [16:0] du;
		logic signed [16:0] dv;
	} side_t;

	// one divider stage
	typedef struct packed {
		logic [10:0] den;
		logic [10:0] rem;
		logic [31:0] quo;
		side_t       side;
	} div_stage_t;

endpackage

// File: rtl/depth_pixel_to_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Depth word to 3-D point: divide, pinhole back-projection, rigid transform.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  pixel    pixel_valid / pixel_ready  pixel_t (raw_depth, column, line)
//  result   result_valid / result_ready point_t (point_x/y/z, point_valid)
//  config   cfg_we                     cfg_index, cfg_data
//
// One transaction per cycle unless stalled; stages: entry stage, 32 divider
// stages (one quotient bit each), 5 projection stages, 3 transform stages and
// the output register. Reset clears all valid bits and loads the register
// defaults. A stalled result freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
module depth_pixel_to_point (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  depi_pkg::pixel_t                    pixel,
	output logic                                result_valid,
	input  logic                                result_ready,
	output depi_pkg::point_t                    result,
	input  logic                                cfg_we,
	input  logic [depi_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [depi_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import depi_pkg::*;

	logic [31:0] principal_point_q;
	logic [63:0] inverse_focal_q;
	logic [10:0] disparity_offset_q;
	logic [31:0] depth_scale_q;
	logic [63:0] row_x_q, row_y_q, row_z_q;
	logic        en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			principal_point_q  <= RST_PRINCIPAL_POINT;
			inverse_focal_q    <= RST_INVERSE_FOCAL;
			disparity_offset_q <= RST_DISPARITY_OFFSET;
			depth_scale_q      <= RST_DEPTH_SCALE;
			row_x_q            <= RST_ROW_X;
			row_y_q            <= RST_ROW_Y;
			row_z_q            <= RST_ROW_Z;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PRINCIPAL_POINT:  principal_point_q  <= cfg_data[31:0];
				CFG_INVERSE_FOCAL:    inverse_focal_q    <= cfg_data;
				CFG_DISPARITY_OFFSET: disparity_offset_q <= cfg_data[10:0];
				CFG_DEPTH_SCALE:      depth_scale_q      <= cfg_data[31:0];
				CFG_ROW_X:            row_x_q            <= cfg_data;
				CFG_ROW_Y:            row_y_q            <= cfg_data;
				CFG_ROW_Z:            row_z_q            <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline advances unless a result is held
	assign en          = !result_valid || result_ready;
	assign pixel_ready = en;

	// entry stage: byte swap, range check, divisor and centered pixel
	logic [15:0] d;
	logic        vld_s1;
	logic [10:0] den_s1;
	side_t       side_s1;

	assign d = {pixel.raw_depth[7:0], pixel.raw_depth[15:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.miss <= (d == 16'd0) || (d >= {5'd0, disparity_offset_q});
			den_s1       <= disparity_offset_q - d[10:0];
			side_s1.du   <= $signed({1'b0, pixel.column, 6'd0})
				- $signed({1'b0, principal_point_q[31:16]});
			side_s1.dv   <= $signed({1'b0, pixel.line, 6'd0})
				- $signed({1'b0, principal_point_q[15:0]});
		end
	end

	// depth division
	logic        vld_d;
	logic [31:0] quo_d;
	side_t       side_d;

	depi_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.num      (depth_scale_q),
		.in_vld   (vld_s1),
		.in_den   (den_s1),
		.in_side  (side_s1),
		.out_vld  (vld_d),
		.out_quo  (quo_d),
		.out_side (side_d)
	);

	// projection stages
	logic               vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic               miss_s2, miss_s3, miss_s4, miss_s5, miss_s6;
	logic [31:0]        z_s2, z_s3, z_s4, z_s5, z_s6;
	logic signed [49:0] px_s2, py_s2;
	logic               nx_s3, ny_s3, nx_s4, ny_s4, nx_s5, ny_s5;
	logic [48:0]        mx_s3, my_s3;
	logic [56:0]        hx_s4, hy_s4;
	logic [55:0]        lx_s4, ly_s4;
	logic [43:0]        rx_s5, ry_s5;
	logic signed [44:0] x_s6, y_s6;
	logic [57:0]        sumx, sumy;

	assign sumx = hx_s4 + {26'd0, lx_s4[55:24]};
	assign sumy = hy_s4 + {26'd0, ly_s4[55:24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_d;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// offset times depth
			miss_s2 <= side_d.miss;
			z_s2    <= quo_d;
			px_s2   <= side_d.du * $signed({1'b0, quo_d});
			py_s2   <= side_d.dv * $signed({1'b0, quo_d});
			// magnitude and sign
			miss_s3 <= miss_s2;
			z_s3    <= z_s2;
			nx_s3   <= px_s2[49];
			ny_s3   <= py_s2[49];
			mx_s3   <= px_s2[49] ? 49'(-px_s2) : px_s2[48:0];
			my_s3   <= py_s2[49] ? 49'(-py_s2) : py_s2[48:0];
			// split products with inverse focal length
			miss_s4 <= miss_s3;
			z_s4    <= z_s3;
			nx_s4   <= nx_s3;
			ny_s4   <= ny_s3;
			hx_s4   <= mx_s3[48:24] * inverse_focal_q[63:32];
			lx_s4   <= mx_s3[23:0] * inverse_focal_q[63:32];
			hy_s4   <= my_s3[48:24] * inverse_focal_q[31:0];
			ly_s4   <= my_s3[23:0] * inverse_focal_q[31:0];
			// recombine and scale down
			miss_s5 <= miss_s4;
			z_s5    <= z_s4;
			nx_s5   <= nx_s4;
			ny_s5   <= ny_s4;
			rx_s5   <= sumx[57:14];
			ry_s5   <= sumy[57:14];
			// restore sign, truncated toward zero
			miss_s6 <= miss_s5;
			z_s6    <= z_s5;
			x_s6    <= nx_s5 ? -$signed({1'b0, rx_s5}) : $signed({1'b0, rx_s5});
			y_s6    <= ny_s5 ? -$signed({1'b0, ry_s5}) : $signed({1'b0, ry_s5});
		end
	end

	// rigid transform, three rows
	logic signed [31:0] tx, ty, tz;

	depi_row u_row_x (.clk(clk), .en(en), .row(row_x_q), .x(x_s6), .y(y_s6), .z(z_s6),
		.res(tx));
	depi_row u_row_y (.clk(clk), .en(en), .row(row_y_q), .x(x_s6), .y(y_s6), .z(z_s6),
		.res(ty));
	depi_row u_row_z (.clk(clk), .en(en), .row(row_z_q), .x(x_s6), .y(y_s6), .z(z_s6),
		.res(tz));

	// flags alongside transform stages
	logic vld_s7, vld_s8, vld_s9;
	logic miss_s7, miss_s8, miss_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7       <= 1'b0;
			vld_s8       <= 1'b0;
			vld_s9       <= 1'b0;
			result_valid <= 1'b0;
		end else if (en) begin
			vld_s7       <= vld_s6;
			vld_s8       <= vld_s7;
			vld_s9       <= vld_s8;
			result_valid <= vld_s9;
		end
	end

	// output register, missing points read as zero
	always_ff @(posedge clk) begin
		if (en) begin
			miss_s7            <= miss_s6;
			miss_s8            <= miss_s7;
			miss_s9            <= miss_s8;
			result.point_x     <= miss_s9 ? '0 : tx;
			result.point_y     <= miss_s9 ? '0 : ty;
			result.point_z     <= miss_s9 ? '0 : tz;
			result.point_valid <= !miss_s9;
		end
	end

endmodule

// File: rtl/depi_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depi_div
// Pipelined restoring divider: depth_scale / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module depi_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [31:0]          num,
	input  logic                 in_vld,
	input  logic [10:0]          in_den,
	input  depi_pkg::side_t      in_side,
	output logic                 out_vld,
	output logic [31:0]          out_quo,
	output depi_pkg::side_t      out_side
);
	import depi_pkg::*;

	div_stage_t st_s [DIV_STAGES];
	logic       vld_s [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [10:0] den_in;
		logic [10:0] rem_in;
		logic [31:0] quo_in;
		side_t       side_in;
		logic        vld_in;
		logic [11:0] trial;
		logic        ge;

		if (i == 0) begin : g_first
			assign den_in  = in_den;
			assign rem_in  = '0;
			assign quo_in  = '0;
			assign side_in = in_side;
			assign vld_in  = in_vld;
		end else begin : g_next
			assign den_in  = st_s[i-1].den;
			assign rem_in  = st_s[i-1].rem;
			assign quo_in  = st_s[i-1].quo;
			assign side_in = st_s[i-1].side;
			assign vld_in  = vld_s[i-1];
		end

		// shift in next numerator bit and try to subtract
		always_comb begin
			trial = {rem_in, num[DIV_STAGES-1-i]};
			ge    = trial >= {1'b0, den_in};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[i].den  <= den_in;
				st_s[i].rem  <= ge ? 11'(trial - {1'b0, den_in}) : trial[10:0];
				st_s[i].quo  <= {quo_in[30:0], ge};
				st_s[i].side <= side_in;
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES-1];
	assign out_quo  = st_s[DIV_STAGES-1].quo;
	assign out_side = st_s[DIV_STAGES-1].side;

endmodule

// File: rtl/depi_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depi_row
// One row of the rigid transform: products, two-level sum, floor and clamp.
// ----------------------------------------------------------------------------
module depi_row (
	input  logic               clk,
	input  logic               en,
	input  logic [63:0]        row,
	input  logic signed [44:0] x,
	input  logic signed [44:0] y,
	input  logic [31:0]        z,
	output logic signed [31:0] res
);
	import depi_pkg::*;

	logic signed [63:0] p0_s1, p1_s1, p2_s1, pt_s1;
	logic signed [63:0] a_s2, b_s2;
	logic signed [63:0] acc_s3;
	logic signed [63:0] sh;

	always_ff @(posedge clk) begin
		if (en) begin
			// coefficient products and shifted translation
			p0_s1  <= $signed(row[63:48]) * x;
			p1_s1  <= $signed(row[47:32]) * y;
			p2_s1  <= $signed(row[31:16]) * $signed({1'b0, z});
			pt_s1  <= $signed({{26{row[15]}}, row[15:0], 22'd0});
			// pair sums
			a_s2   <= p0_s1 + p1_s1;
			b_s2   <= p2_s1 + pt_s1;
			// final sum
			acc_s3 <= a_s2 + b_s2;
		end
	end

	// floor divide by 2^14, then clamp to 32 bits
	always_comb begin
		sh = acc_s3 >>> 14;
		if (sh > 64'sd2147483647)
			res = 32'sh7FFF_FFFF;
		else if (sh < -64'sd2147483648)
			res = 32'sh8000_0000;
		else
			res = sh[31:0];
	end

endmodule
